@@ rtl/mds_pkg.sv @@
// ----------------------------------------------------------------------------
// mds_pkg
// Shared types and constants for the MCU data space map unit.
// ----------------------------------------------------------------------------
package mds_pkg;

  localparam int IO_REG_COUNT = 64;
  localparam int SRAM_DEPTH   = 2048;

  // Unified backing memory: register file, I/O store and SRAM sit at their
  // data-space addresses, so the memory index is the data address itself.
  localparam int SRAM_BASE = 'h100;
  localparam int MEM_DEPTH = SRAM_BASE + SRAM_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [15:0] REGFILE_LAST = 16'h001F;
  localparam logic [15:0] IO_LAST      = 16'h005F;
  localparam logic [15:0] EXTIO_LAST   = 16'h00FF;
  localparam logic [15:0] SRAM_LAST    = 16'h08FF;
  localparam logic [15:0] IO_BASE      = 16'h0020;
  localparam logic [15:0] MEM_END      = 16'(MEM_DEPTH);
  localparam logic [15:0] IO_COUNT_W   = 16'(IO_REG_COUNT);

  localparam logic [15:0] OFF_SPL    = 16'h003D;
  localparam logic [15:0] OFF_SPH    = 16'h003E;
  localparam logic [15:0] OFF_STATUS = 16'h003F;

  localparam logic [15:0] SP_RESET   = 16'h08FF;
  localparam logic [15:0] SP_HI_MASK = 16'hFF00;

  typedef enum logic [1:0] {
    KIND_DATA_LOAD  = 2'd0,
    KIND_DATA_STORE = 2'd1,
    KIND_IO_LOAD    = 2'd2,
    KIND_IO_STORE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_MEM,
    SEL_SPL,
    SEL_SPH,
    SEL_SR
  } sel_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

endpackage

@@ rtl/mds_if.sv @@
// ----------------------------------------------------------------------------
// mds_req_if / mds_rsp_if
// Valid/ready channels carrying access requests and their results.
// ----------------------------------------------------------------------------
interface mds_req_if
  import mds_pkg::*;
();
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, kind, address, write_data, input ready);
  modport sink   (input valid, kind, address, write_data, output ready);
endinterface

interface mds_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

@@ rtl/mds_ram.sv @@
// ----------------------------------------------------------------------------
// mds_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mcu_data_space_map_unit.sv @@
// ----------------------------------------------------------------------------
// mcu_data_space_map_unit
// Byte load/store decoder over register file, I/O space and SRAM.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one access (kind, address, write_data); rsp returns exactly
//   one item per access (read_data, status). Both are valid/ready channels.
//   At the accepting edge, stores commit to memory or to the stack pointer
//   and status registers, and loads issue a read of the unified RAM. The
//   result then passes through the read stage and the output register,
//   which holds it while rsp stalls.
//   Throughput is one item per cycle while rsp does not stall, set by the
//   single RAM read port and a write port that commits stores at acceptance,
//   so back-to-back accesses to the same byte see each other without forwarding.
//   After reset the block sweeps the unified RAM to zero, one entry a cycle,
//   over all MEM_DEPTH (2304) entries, with req.ready low; the stack pointer resets
//   to 0x08FF and the status byte to zero at once.
//   When rsp stalls, the output register holds its item and one more item
//   waits in the read stage; req.ready then drops until rsp drains.
// ----------------------------------------------------------------------------
module mcu_data_space_map_unit
  import mds_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  mds_req_if.sink      req,
  mds_rsp_if.source    rsp
);

  state_t              state, state_next;
  logic [MEM_AW-1:0]   clr_cnt;
  logic                clr_done;

  logic [15:0]         sp;
  logic [7:0]          status_byte;

  // decode
  logic                is_store, is_io;
  logic [15:0]         io_off;
  sel_t                io_sel, dec_sel;
  logic                io_err, dec_err;
  logic [MEM_AW-1:0]   io_idx, dec_idx;
  logic [7:0]          direct_val;

  logic                acc, adv;

  // RAM ports
  logic                ram_we, ram_re;
  logic [MEM_AW-1:0]   ram_waddr;
  logic [7:0]          ram_wdata, ram_rdata;

  // read stage
  logic                p_valid, p_mem, p_err;
  logic [7:0]          p_val;

  // output register
  logic                o_valid, o_status;
  logic [7:0]          o_data;

  assign is_store = req.kind[0];
  assign is_io    = req.kind[1];
  assign io_off   = is_io ? req.address : req.address - IO_BASE;

  // I/O decode: stack pointer and status win over the register count test
  always_comb begin
    io_sel = SEL_NONE;
    io_err = 1'b0;
    io_idx = MEM_AW'(io_off + IO_BASE);
    if (io_off == OFF_SPL) begin
      io_sel = SEL_SPL;
    end else if (io_off == OFF_SPH) begin
      io_sel = SEL_SPH;
    end else if (io_off == OFF_STATUS) begin
      io_sel = SEL_SR;
    end else if (io_off < IO_COUNT_W) begin
      io_sel = SEL_MEM;
    end else begin
      io_err = 1'b1;
    end
  end

  always_comb begin
    dec_sel = SEL_NONE;
    dec_err = 1'b0;
    dec_idx = MEM_AW'(req.address);
    if (is_io || (req.address > REGFILE_LAST && req.address <= IO_LAST)) begin
      dec_sel = io_sel;
      dec_err = io_err;
      dec_idx = io_idx;
    end else if (req.address <= REGFILE_LAST) begin
      dec_sel = SEL_MEM;
    end else if (req.address <= EXTIO_LAST) begin
      dec_sel = SEL_NONE;
    end else if (req.address <= SRAM_LAST) begin
      // SRAM beyond the fitted depth reads as ignored space
      if (req.address < MEM_END) begin
        dec_sel = SEL_MEM;
      end
    end else begin
      dec_err = 1'b1;
    end
  end

  always_comb begin
    case (dec_sel)
      SEL_SPL: direct_val = sp[7:0];
      SEL_SPH: direct_val = sp[15:8];
      SEL_SR:  direct_val = status_byte;
      default: direct_val = 8'h00;
    endcase
  end

  assign adv       = p_valid && (!o_valid || rsp.ready);
  assign req.ready = (state == ST_RUN) && (!p_valid || adv);
  assign acc       = req.valid && req.ready;
  assign clr_done  = (clr_cnt == MEM_AW'(MEM_DEPTH - 1));

  // next state
  always_comb begin
    case (state)
      ST_CLEAR: state_next = clr_done ? ST_RUN : ST_CLEAR;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // outputs: RAM write port is the clearing sweep or a committed store
  always_comb begin
    ram_re    = acc && !is_store && (dec_sel == SEL_MEM) && !dec_err;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = 8'h00;
      end
      ST_RUN: begin
        ram_we    = acc && is_store && (dec_sel == SEL_MEM) && !dec_err;
        ram_waddr = dec_idx;
        ram_wdata = req.write_data;
      end
      default: begin
        ram_we    = 1'b0;
        ram_waddr = dec_idx;
        ram_wdata = req.write_data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp          <= SP_RESET;
      status_byte <= 8'h00;
    end else if (acc && is_store && !dec_err) begin
      case (dec_sel)
        SEL_SPL: sp          <= (sp & SP_HI_MASK) | {8'h00, req.write_data};
        SEL_SPH: sp          <= {req.write_data, sp[7:0]};
        SEL_SR:  status_byte <= req.write_data;
        default: ;
      endcase
    end
  end

  mds_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (dec_idx),
    .rdata (ram_rdata)
  );

  // read stage: RAM data is held while stalled as no new read issues
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (acc) begin
      p_valid <= 1'b1;
    end else if (adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_mem <= !is_store && (dec_sel == SEL_MEM) && !dec_err;
      p_err <= dec_err;
      p_val <= (is_store || dec_err) ? 8'h00 : direct_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_data   <= p_mem ? ram_rdata : p_val;
      o_status <= p_err;
    end
  end

  assign rsp.valid     = o_valid;
  assign rsp.read_data = o_data;
  assign rsp.status    = o_status;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !(req.valid && req.ready))
    else $error("item accepted during clearing sweep");

  a_rdata_held: assert property (@(posedge clk) disable iff (rst)
    (p_valid && !adv) |=> $stable(ram_rdata))
    else $error("RAM read data changed under a stalled item");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status) |-> (rsp.read_data == 8'h00))
    else $error("error result carries non-zero data");

  a_no_mem_write_on_err: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && ram_we) |-> (acc && is_store && !dec_err))
    else $error("RAM written without a valid store");
`endif

endmodule

@@ sim/tb_mcu_data_space_map_unit.sv @@
// ----------------------------------------------------------------------------
// tb_mcu_data_space_map_unit
// Self-checking bench for the data space map unit. Accesses go in over the
// req channel and their results come back over rsp. A behavioural model of
// the register file, I/O store, stack pointer, status byte and SRAM predicts
// each result. Results are checked in order against those predictions while
// both channels idle at random in two phases, then run without idles in a third.
// ----------------------------------------------------------------------------
module tb_mcu_data_space_map_unit
  import mds_pkg::*;
;

  localparam int RANDOM_ITEMS = 1100;
  localparam int PHASE1_START = 400;
  localparam int PHASE2_START = 800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [15:0] SP_LO_OFFSET = 16'h003D;
  localparam logic [15:0] SP_HI_OFFSET = 16'h003E;
  localparam logic [15:0] SREG_OFFSET  = 16'h003F;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  write_data;
  } access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
  } access_result_t;

  logic clk;
  logic rst;

  mds_req_if req ();
  mds_rsp_if rsp ();

  mcu_data_space_map_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Behavioural copy of the block's storage
  logic [7:0]  gpr_bank  [32];
  logic [7:0]  io_bank   [64];
  logic [7:0]  sram_bank [SRAM_DEPTH];
  logic [15:0] sp_word;
  logic [7:0]  sreg_byte;

  access_t        accesses[$];
  access_result_t predicted_reads[$];
  int             accepted;
  int             errors;
  int             cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Returns 1 on an out-of-range offset
  function automatic logic io_port(input logic is_store, input logic [15:0] off,
                                   input logic [7:0] wd, output logic [7:0] rd);
    rd = 8'h00;
    if (off == SP_LO_OFFSET) begin
      if (is_store) sp_word[7:0] = wd;
      else rd = sp_word[7:0];
      return 1'b0;
    end
    if (off == SP_HI_OFFSET) begin
      if (is_store) sp_word[15:8] = wd;
      else rd = sp_word[15:8];
      return 1'b0;
    end
    if (off == SREG_OFFSET) begin
      if (is_store) sreg_byte = wd;
      else rd = sreg_byte;
      return 1'b0;
    end
    if (off < IO_REG_COUNT) begin
      if (is_store) io_bank[off[5:0]] = wd;
      else rd = io_bank[off[5:0]];
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic access_result_t map_access(input access_t acc);
    logic          is_store;
    logic          err;
    logic [7:0]    rd;
    logic [15:0]   idx;
    access_result_t res;
    is_store = acc.kind[0];
    err      = 1'b0;
    rd       = 8'h00;
    if (acc.kind == KIND_IO_LOAD || acc.kind == KIND_IO_STORE) begin
      err = io_port(is_store, acc.address, acc.write_data, rd);
    end else if (acc.address <= 16'h001F) begin
      if (is_store) gpr_bank[acc.address[4:0]] = acc.write_data;
      else rd = gpr_bank[acc.address[4:0]];
    end else if (acc.address <= 16'h005F) begin
      err = io_port(is_store, acc.address - 16'h0020, acc.write_data, rd);
    end else if (acc.address <= 16'h00FF) begin
      // extended I/O: drop stores, loads read zero
    end else if (acc.address <= 16'h08FF) begin
      idx = acc.address - 16'h0100;
      if (idx < SRAM_DEPTH) begin
        if (is_store) sram_bank[idx[$clog2(SRAM_DEPTH)-1:0]] = acc.write_data;
        else rd = sram_bank[idx[$clog2(SRAM_DEPTH)-1:0]];
      end
    end else begin
      err = 1'b1;
    end
    res.read_data = (err || is_store) ? 8'h00 : rd;
    res.status    = err;
    return res;
  endfunction

  task automatic queue_access(input kind_t kind, input logic [15:0] address,
                              input logic [7:0] write_data);
    access_t acc;
    acc.kind       = kind;
    acc.address    = address;
    acc.write_data = write_data;
    accesses.push_back(acc);
  endtask

  function automatic access_t random_access();
    access_t acc;
    int      region;
    logic    is_io;
    region = $urandom_range(99);
    is_io  = 1'b0;
    if (region < 15) begin
      acc.address = 16'($urandom_range(16'h001F));
    end else if (region < 30) begin
      acc.address = 16'($urandom_range(16'h005F, 16'h0020));
    end else if (region < 35) begin
      acc.address = 16'($urandom_range(16'h00FF, 16'h0060));
    end else if (region < 48) begin
      // keep to a few hot bytes so loads find earlier stores
      acc.address = $urandom_range(1) ? 16'($urandom_range(16'h010F, 16'h0100))
                                      : 16'($urandom_range(16'h08FF, 16'h08F0));
    end else if (region < 60) begin
      acc.address = 16'($urandom_range(16'h08FF, 16'h0100));
    end else if (region < 68) begin
      acc.address = 16'($urandom_range(16'hFFFF, 16'h0900));
    end else if (region < 92) begin
      is_io       = 1'b1;
      acc.address = 16'($urandom_range(63));
    end else begin
      is_io       = 1'b1;
      acc.address = 16'($urandom_range(16'hFFFF, 16'h0040));
    end
    acc.kind       = kind_t'({is_io, 1'($urandom_range(1))});
    acc.write_data = 8'($urandom_range(255));
    return acc;
  endfunction

  function automatic int send_idle_pct();
    if (accepted < PHASE1_START) return 19;
    if (accepted < PHASE2_START) return 66;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted < PHASE1_START) return 66;
    if (accepted < PHASE2_START) return 19;
    return 0;
  endfunction

  // Driver: predict on acceptance, then advance or hold the item on req
  always @(posedge clk) begin : drive_req
    access_t acc;
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        acc.kind       = req.kind;
        acc.address    = req.address;
        acc.write_data = req.write_data;
        predicted_reads.push_back(map_access(acc));
        accepted++;
      end
      if (!req.valid || req.ready) begin
        if (accesses.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          acc            = accesses.pop_front();
          req.valid      <= 1'b1;
          req.kind       <= acc.kind;
          req.address    <= acc.address;
          req.write_data <= acc.write_data;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction
  always @(posedge clk) begin : check_rsp
    access_result_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct());
      if (rsp.valid && rsp.ready) begin
        if (predicted_reads.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual read_data=%02h status=%b",
                   $time, rsp.read_data, rsp.status);
        end else begin
          want = predicted_reads.pop_front();
          if (rsp.read_data !== want.read_data) begin
            errors++;
            $display("%0t: read_data mismatch, expected %02h actual %02h",
                     $time, want.read_data, rsp.read_data);
          end
          if (rsp.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %b actual %b",
                     $time, want.status, rsp.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL mcu_data_space_map_unit");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.kind       = KIND_DATA_LOAD;
    req.address    = 16'h0000;
    req.write_data = 8'h00;
    rsp.ready      = 1'b0;
    accepted       = 0;
    errors         = 0;
    cycles         = 0;
    foreach (gpr_bank[i]) gpr_bank[i] = 8'h00;
    foreach (io_bank[i]) io_bank[i] = 8'h00;
    foreach (sram_bank[i]) sram_bank[i] = 8'h00;
    sp_word   = 16'h08FF;
    sreg_byte = 8'h00;

    // Stack pointer reset value, through both ways in
    queue_access(KIND_IO_LOAD,    16'h003E, 8'h00);
    queue_access(KIND_DATA_LOAD,  16'h005D, 8'h00);
    // Register file ends
    queue_access(KIND_DATA_LOAD,  16'h0000, 8'hFF);
    queue_access(KIND_DATA_STORE, 16'h001F, 8'hFF);
    queue_access(KIND_DATA_LOAD,  16'h001F, 8'h00);
    // I/O store through data space and directly
    queue_access(KIND_DATA_STORE, 16'h0020, 8'hA5);
    queue_access(KIND_IO_LOAD,    16'h0000, 8'h00);
    queue_access(KIND_IO_STORE,   16'h003C, 8'h5A);
    queue_access(KIND_DATA_LOAD,  16'h005C, 8'h00);
    // Stack pointer bytes and status byte
    queue_access(KIND_IO_STORE,   16'h003D, 8'h34);
    queue_access(KIND_IO_STORE,   16'h003E, 8'h12);
    queue_access(KIND_DATA_LOAD,  16'h005E, 8'h00);
    queue_access(KIND_IO_LOAD,    16'h003D, 8'h00);
    queue_access(KIND_DATA_STORE, 16'h005F, 8'h80);
    queue_access(KIND_IO_LOAD,    16'h003F, 8'h00);
    // I/O offsets out of range
    queue_access(KIND_IO_LOAD,    16'h0040, 8'h00);
    queue_access(KIND_IO_STORE,   16'hFFFF, 8'hFF);
    // Extended I/O is ignored
    queue_access(KIND_DATA_STORE, 16'h0060, 8'h55);
    queue_access(KIND_DATA_LOAD,  16'h0060, 8'h00);
    queue_access(KIND_DATA_LOAD,  16'h00FF, 8'h00);
    // SRAM ends
    queue_access(KIND_DATA_STORE, 16'h0100, 8'h01);
    queue_access(KIND_DATA_LOAD,  16'h0100, 8'h00);
    queue_access(KIND_DATA_STORE, 16'h08FF, 8'hFE);
    queue_access(KIND_DATA_LOAD,  16'h08FF, 8'h00);
    // Data addresses past SRAM
    queue_access(KIND_DATA_LOAD,  16'h0900, 8'h00);
    queue_access(KIND_DATA_STORE, 16'hFFFF, 8'h77);

    repeat (RANDOM_ITEMS) accesses.push_back(random_access());

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Sample away from the active edge so queue updates have settled
    while (accesses.size() != 0 || req.valid || predicted_reads.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS mcu_data_space_map_unit");
    end else begin
      $display("FAIL mcu_data_space_map_unit");
    end
    $finish;
  end

endmodule
